FILE: design/gdr_pkg.sv
// Shared types and constants for the grid DDA ray caster.
`timescale 1ns / 1ps

package gdr_pkg;

  localparam int IDX_W      = 8;
  localparam int POS_W      = 12;
  localparam int DELTA_W    = 16;
  localparam int DIST_OUT_W = 20;
  localparam int CELL_W     = 4;
  localparam int PAL_W      = 2;
  localparam int SHADE_W    = 3;

  localparam logic [DIST_OUT_W-1:0] DIST_MAX  = 20'hFFFFF;
  localparam logic [SHADE_W-1:0]    SHADE_MAX = 3'd7;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_CAST  = 1'b1;

  // Palette codes by side crossed and cell parity.
  localparam logic [PAL_W-1:0] PAL_X_EVEN = 2'd0;
  localparam logic [PAL_W-1:0] PAL_Y_EVEN = 2'd1;
  localparam logic [PAL_W-1:0] PAL_X_ODD  = 2'd2;
  localparam logic [PAL_W-1:0] PAL_Y_ODD  = 2'd3;

  // One map cell write toward the wall map.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic             wall;
  } map_wr_t;

endpackage

FILE: design/gdr_map.sv
// Wall map memory with per-cell valid bits and a registered read port.
`timescale 1ns / 1ps

module gdr_map #(
  parameter int DEPTH = 256
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  gdr_pkg::map_wr_t        wr,
  input  logic [gdr_pkg::IDX_W-1:0] rd_addr,
  output logic                    rd_wall
);
  import gdr_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic             mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic             mem_q_r;
  logic             vld_q_r;

  // Data store: no reset, never-written cells are masked by the valid bits.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[AW-1:0]] <= wr.wall;
    end
    mem_q_r <= mem[rd_addr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      vld_q_r <= 1'b0;
    end else begin
      if (wr.en) begin
        vld_r[wr.addr[AW-1:0]] <= 1'b1;
      end
      vld_q_r <= vld_r[rd_addr[AW-1:0]];
    end
  end

  assign rd_wall = mem_q_r & vld_q_r;

endmodule

FILE: design/grid_dda_raycaster.sv
// Top level of the grid DDA ray caster: command decode, setup and grid walk.
`timescale 1ns / 1ps

// Usage
// - Command channel: a transaction is taken at a rising edge with start high
//   and busy low. in_command selects a map cell write or a ray cast.
// - A map write lands at the accepting edge; busy stays low, so another
//   transaction may follow in the next cycle. Writes beyond the map are dropped.
// - A cast raises busy. The setup state forms both initial side distances
//   (one multiply per axis), then the walk issues one grid step per cycle,
//   each step doing one read of the wall map memory. The read result is
//   checked in the following cycle while the next step is already issued.
// - A cast ends at the first step that finds a wall, or after MAX_STEPS steps
//   when none does. busy falls in the cycle the result shows.
// - Result channel: out_valid strobes for exactly one cycle with the result
//   fields. The receiver cannot stall; it must take the transaction then.
// - Reset (rst_n low at a clock edge) clears every map cell and aborts any
//   cast in flight.
module grid_dda_raycaster #(
  parameter int MAP_DIM   = 16,
  parameter int MAX_STEPS = 15,
  parameter int FRAC_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_command,
  input  logic [gdr_pkg::IDX_W-1:0]          in_cell_index,
  input  logic                               in_cell_wall,
  input  logic [gdr_pkg::POS_W-1:0]          in_pos_x,
  input  logic [gdr_pkg::POS_W-1:0]          in_pos_y,
  input  logic [gdr_pkg::DELTA_W-1:0]        in_delta_x,
  input  logic [gdr_pkg::DELTA_W-1:0]        in_delta_y,
  input  logic                               in_ray_neg_x,
  input  logic                               in_ray_neg_y,
  output logic                               out_valid,
  output logic                               out_hit,
  output logic                               out_side,
  output logic [gdr_pkg::DIST_OUT_W-1:0]     out_distance,
  output logic [gdr_pkg::CELL_W-1:0]         out_cell_x,
  output logic [gdr_pkg::CELL_W-1:0]         out_cell_y,
  output logic [gdr_pkg::PAL_W-1:0]          out_palette,
  output logic [gdr_pkg::SHADE_W-1:0]        out_shade
);
  import gdr_pkg::*;

  // Only the first 256 cells can ever be written; the rest always read clear.
  localparam int CELLS     = MAP_DIM * MAP_DIM;
  localparam int MEM_DEPTH = (CELLS < 256) ? CELLS : 256;
  localparam int MAW       = $clog2(MEM_DEPTH);
  localparam int FW        = $clog2(CELLS);
  localparam int MW        = $clog2(MAP_DIM);
  localparam int CW        = POS_W - FRAC_BITS + 8;   // signed cell coordinate
  localparam int SPAN_W    = FRAC_BITS + 1;
  localparam int PROD_W    = SPAN_W + DELTA_W;
  localparam int DW_RAW    = DELTA_W + 1 + $clog2(MAX_STEPS + 1);
  localparam int DW        = (DW_RAW > DIST_OUT_W + 1) ? DW_RAW : DIST_OUT_W + 1;
  localparam int SCW       = $clog2(MAX_STEPS + 1);

  localparam logic signed [CW-1:0] ONE_S = CW'(1);
  localparam logic signed [CW-1:0] DIM_S = CW'(MAP_DIM);
  localparam logic [SPAN_W-1:0]    ONE_F = SPAN_W'(1) << FRAC_BITS;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SETUP = 2'd1;
  localparam logic [1:0] ST_WALK  = 2'd2;

  // Control
  logic [1:0]     state_r, state_nxt;
  logic [SCW-1:0] cnt_r;
  logic           p_vld_r;

  // Cast operands, held for the whole walk
  logic [FRAC_BITS-1:0] frac_x_r, frac_y_r;
  logic [DELTA_W-1:0]   delta_x_r, delta_y_r;
  logic                 neg_x_r, neg_y_r;

  // Walk position and side distances
  logic signed [CW-1:0] cx_r, cy_r;
  logic [DW-1:0]        dist_x_r, dist_y_r;

  // Step in flight: waits in these registers for its map read
  logic                 p_along_r, p_oob_r, p_inmem_r, p_last_r;
  logic signed [CW-1:0] p_cx_r, p_cy_r;
  logic [DW-1:0]        p_dist_r;

  // Result registers
  logic                  out_valid_r, out_hit_r, out_side_r;
  logic [DIST_OUT_W-1:0] out_distance_r;
  logic [CELL_W-1:0]     out_cell_x_r, out_cell_y_r;
  logic [PAL_W-1:0]      out_palette_r;
  logic [SHADE_W-1:0]    out_shade_r;

  // Combinational
  logic                 accept, cast_go;
  map_wr_t              map_wr;
  logic [IDX_W-1:0]     rd_addr;
  logic                 rd_wall;
  logic [SPAN_W-1:0]    span_x, span_y;
  logic [PROD_W-1:0]    prod_x, prod_y;
  logic                 issue, along;
  logic signed [CW-1:0] ncx, ncy;
  logic                 in_grid;
  logic [FW-1:0]        flat;
  logic                 in_mem;
  logic                 wall, finish;
  logic [DW-1:0]        whole;

  assign accept  = start && (state_r == ST_IDLE);
  assign cast_go = accept && (in_command == CMD_CAST);
  assign busy    = (state_r != ST_IDLE);

  // Map writes only at acceptance; indexes past the map are dropped.
  always_comb begin
    map_wr.en   = accept && (in_command == CMD_WRITE) &&
                  ({5'b0, in_cell_index} < 13'(CELLS));
    map_wr.addr = in_cell_index;
    map_wr.wall = in_cell_wall;
  end

  gdr_map #(
    .DEPTH (MEM_DEPTH)
  ) u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (map_wr),
    .rd_addr (rd_addr),
    .rd_wall (rd_wall)
  );

  // Initial side distances
  always_comb begin
    span_x = neg_x_r ? {1'b0, frac_x_r} : ONE_F - {1'b0, frac_x_r};
    span_y = neg_y_r ? {1'b0, frac_y_r} : ONE_F - {1'b0, frac_y_r};
    prod_x = PROD_W'(span_x) * PROD_W'(delta_x_r);
    prod_y = PROD_W'(span_y) * PROD_W'(delta_y_r);
  end

  // Issue one grid step: pick the axis, move, address the map.
  always_comb begin
    issue   = (state_r == ST_WALK) && (cnt_r < SCW'(MAX_STEPS));
    along   = dist_x_r < dist_y_r;
    ncx     = cx_r;
    ncy     = cy_r;
    if (along) begin
      ncx = neg_x_r ? cx_r - ONE_S : cx_r + ONE_S;
    end else begin
      ncy = neg_y_r ? cy_r - ONE_S : cy_r + ONE_S;
    end
    in_grid = !ncx[CW-1] && !ncy[CW-1] && (ncx < DIM_S) && (ncy < DIM_S);
    flat    = FW'(ncy[MW-1:0]) * FW'(MAP_DIM) + FW'(ncx[MW-1:0]);
    in_mem  = ({1'b0, flat} < (FW + 1)'(MEM_DEPTH));
    rd_addr = IDX_W'(flat[MAW-1:0]);
  end

  // Check the step in flight against its map read.
  always_comb begin
    wall   = p_oob_r || (p_inmem_r && rd_wall);
    finish = p_vld_r && (wall || p_last_r);
    whole  = p_dist_r >> FRAC_BITS;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (cast_go) state_nxt = ST_SETUP;
      ST_SETUP: state_nxt = ST_WALK;
      ST_WALK:  if (finish) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      p_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= finish;
      if (state_r == ST_SETUP) begin
        cnt_r <= '0;
      end else if (issue) begin
        cnt_r <= cnt_r + SCW'(1);
      end
      // Drop the speculative step issued alongside a finishing one.
      p_vld_r <= issue && !finish;
    end
  end

  // Datapath: operands, walk state, step in flight
  always_ff @(posedge clk) begin
    if (cast_go) begin
      frac_x_r  <= in_pos_x[FRAC_BITS-1:0];
      frac_y_r  <= in_pos_y[FRAC_BITS-1:0];
      delta_x_r <= in_delta_x;
      delta_y_r <= in_delta_y;
      neg_x_r   <= in_ray_neg_x;
      neg_y_r   <= in_ray_neg_y;
      cx_r      <= CW'(in_pos_x >> FRAC_BITS);
      cy_r      <= CW'(in_pos_y >> FRAC_BITS);
    end
    if (state_r == ST_SETUP) begin
      dist_x_r <= DW'(prod_x >> FRAC_BITS);
      dist_y_r <= DW'(prod_y >> FRAC_BITS);
    end
    if (issue) begin
      // Advance as if no wall; a hit ends the walk before this matters.
      cx_r <= ncx;
      cy_r <= ncy;
      if (along) begin
        dist_x_r <= dist_x_r + DW'(delta_x_r);
      end else begin
        dist_y_r <= dist_y_r + DW'(delta_y_r);
      end
      p_along_r <= along;
      p_oob_r   <= !in_grid;
      p_inmem_r <= in_mem;
      p_last_r  <= (cnt_r == SCW'(MAX_STEPS - 1));
      p_cx_r    <= ncx;
      p_cy_r    <= ncy;
      p_dist_r  <= along ? dist_x_r : dist_y_r;
    end
  end

  // Result fields; a walk with no wall reports all zero.
  always_ff @(posedge clk) begin
    if (finish) begin
      if (wall) begin
        out_hit_r      <= 1'b1;
        out_side_r     <= !p_along_r;
        out_distance_r <= (p_dist_r > DW'(DIST_MAX)) ? DIST_MAX
                                                     : p_dist_r[DIST_OUT_W-1:0];
        out_cell_x_r   <= p_cx_r[CELL_W-1:0];
        out_cell_y_r   <= p_cy_r[CELL_W-1:0];
        if (p_along_r) begin
          out_palette_r <= p_cy_r[0] ? PAL_X_ODD : PAL_X_EVEN;
        end else begin
          out_palette_r <= p_cx_r[0] ? PAL_Y_ODD : PAL_Y_EVEN;
        end
        out_shade_r    <= (whole > DW'(SHADE_MAX)) ? '0
                                                   : SHADE_MAX - whole[SHADE_W-1:0];
      end else begin
        out_hit_r      <= 1'b0;
        out_side_r     <= 1'b0;
        out_distance_r <= '0;
        out_cell_x_r   <= '0;
        out_cell_y_r   <= '0;
        out_palette_r  <= '0;
        out_shade_r    <= '0;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_hit      = out_hit_r;
  assign out_side     = out_side_r;
  assign out_distance = out_distance_r;
  assign out_cell_x   = out_cell_x_r;
  assign out_cell_y   = out_cell_y_r;
  assign out_palette  = out_palette_r;
  assign out_shade    = out_shade_r;

endmodule

FILE: sim/gdr_result_checker.sv
// Result checker for the grid DDA ray caster: tracks the wall map, predicts and compares casts.
`timescale 1ns / 1ps

module gdr_result_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  logic                           in_command,
  input  logic [gdr_pkg::IDX_W-1:0]      in_cell_index,
  input  logic                           in_cell_wall,
  input  logic [gdr_pkg::POS_W-1:0]      in_pos_x,
  input  logic [gdr_pkg::POS_W-1:0]      in_pos_y,
  input  logic [gdr_pkg::DELTA_W-1:0]    in_delta_x,
  input  logic [gdr_pkg::DELTA_W-1:0]    in_delta_y,
  input  logic                           in_ray_neg_x,
  input  logic                           in_ray_neg_y,
  input  logic                           out_valid,
  input  logic                           out_hit,
  input  logic                           out_side,
  input  logic [gdr_pkg::DIST_OUT_W-1:0] out_distance,
  input  logic [gdr_pkg::CELL_W-1:0]     out_cell_x,
  input  logic [gdr_pkg::CELL_W-1:0]     out_cell_y,
  input  logic [gdr_pkg::PAL_W-1:0]      out_palette,
  input  logic [gdr_pkg::SHADE_W-1:0]    out_shade,
  output int                             rays_in_flight,
  output int                             mismatch_count
);
  import gdr_pkg::*;

  localparam int MAP_DIM   = 16;
  localparam int MAX_STEPS = 15;
  localparam int FRAC_BITS = 8;

  typedef struct packed {
    logic                  hit;
    logic                  side;
    logic [DIST_OUT_W-1:0] distance;
    logic [CELL_W-1:0]     cell_x;
    logic [CELL_W-1:0]     cell_y;
    logic [PAL_W-1:0]      palette;
    logic [SHADE_W-1:0]    shade;
  } ray_result_t;

  bit          wall_map [MAP_DIM*MAP_DIM];
  ray_result_t expected_rays [$];
  int          errors = 0;

  assign mismatch_count = errors;

  // Distance from the viewer to the first boundary on one axis.
  function automatic longint unsigned first_side(logic [POS_W-1:0] pos, logic neg,
                                                 logic [DELTA_W-1:0] delta);
    longint unsigned frac;
    longint unsigned span;
    frac = 64'(pos) & ((64'(1) << FRAC_BITS) - 64'(1));
    span = neg ? frac : (64'(1) << FRAC_BITS) - frac;
    return (span * 64'(delta)) >> FRAC_BITS;
  endfunction

  // Walk the grid from the viewer cell until a wall or the step limit.
  function automatic ray_result_t trace_ray(logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                                            logic [DELTA_W-1:0] dx, logic [DELTA_W-1:0] dy,
                                            logic nx, logic ny);
    ray_result_t     r;
    int              cx;
    int              cy;
    int              n;
    longint unsigned dist_x;
    longint unsigned dist_y;
    longint unsigned d;
    longint unsigned whole;
    bit              along_x;
    bit              wall;
    bit              done;
    r      = '0;
    cx     = int'(px >> FRAC_BITS);
    cy     = int'(py >> FRAC_BITS);
    dist_x = first_side(px, nx, dx);
    dist_y = first_side(py, ny, dy);
    done   = 1'b0;
    for (n = 0; n < MAX_STEPS && !done; n++) begin
      along_x = dist_x < dist_y;
      if (along_x) cx += nx ? -1 : 1;
      else         cy += ny ? -1 : 1;
      // Anything beyond the map edge is solid.
      wall = (cx < 0) || (cy < 0) || (cx >= MAP_DIM) || (cy >= MAP_DIM) ||
             wall_map[cy*MAP_DIM + cx];
      if (!wall) begin
        if (along_x) dist_x += 64'(dx);
        else         dist_y += 64'(dy);
      end else begin
        d          = along_x ? dist_x : dist_y;
        whole      = d >> FRAC_BITS;
        r.hit      = 1'b1;
        r.side     = !along_x;
        r.distance = (d > 64'(DIST_MAX)) ? DIST_MAX : d[DIST_OUT_W-1:0];
        r.cell_x   = cx[CELL_W-1:0];
        r.cell_y   = cy[CELL_W-1:0];
        if (along_x) r.palette = cy[0] ? PAL_X_ODD : PAL_X_EVEN;
        else         r.palette = cx[0] ? PAL_Y_ODD : PAL_Y_EVEN;
        r.shade    = SHADE_MAX - ((whole > 64'(SHADE_MAX)) ? SHADE_MAX
                                                           : whole[SHADE_W-1:0]);
        done       = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    ray_result_t want;
    if (!rst_n) begin
      foreach (wall_map[i]) wall_map[i] = 1'b0;
      expected_rays.delete();
    end else begin
      // Compare before taking a new cast so a same-edge result cannot match it.
      if (out_valid) begin
        if (expected_rays.size() == 0) begin
          $error("result transaction with no cast outstanding");
          errors++;
        end else begin
          want = expected_rays.pop_front();
          check_field("hit", 64'(want.hit), 64'(out_hit));
          check_field("side", 64'(want.side), 64'(out_side));
          check_field("distance", 64'(want.distance), 64'(out_distance));
          check_field("cell_x", 64'(want.cell_x), 64'(out_cell_x));
          check_field("cell_y", 64'(want.cell_y), 64'(out_cell_y));
          check_field("palette", 64'(want.palette), 64'(out_palette));
          check_field("shade", 64'(want.shade), 64'(out_shade));
        end
      end
      if (start && !busy) begin
        if (in_command == CMD_WRITE) begin
          if (int'(in_cell_index) < MAP_DIM*MAP_DIM) wall_map[in_cell_index] = in_cell_wall;
        end else begin
          expected_rays.push_back(trace_ray(in_pos_x, in_pos_y, in_delta_x, in_delta_y,
                                            in_ray_neg_x, in_ray_neg_y));
        end
      end
    end
    rays_in_flight <= expected_rays.size();
  end

endmodule

FILE: sim/tb_grid_dda_raycaster.sv
// Testbench top for the grid DDA ray caster: stimulus, timeout and verdict.
`timescale 1ns / 1ps

module tb_grid_dda_raycaster;
  import gdr_pkg::*;

  // Keep a wide margin over the slowest run.
  localparam int CYCLE_LIMIT = 400000;

  logic                  clk;
  logic                  rst_n         = 1'b0;
  logic                  start         = 1'b0;
  logic                  in_command    = CMD_WRITE;
  logic [IDX_W-1:0]      in_cell_index = '0;
  logic                  in_cell_wall  = 1'b0;
  logic [POS_W-1:0]      in_pos_x      = '0;
  logic [POS_W-1:0]      in_pos_y      = '0;
  logic [DELTA_W-1:0]    in_delta_x    = '0;
  logic [DELTA_W-1:0]    in_delta_y    = '0;
  logic                  in_ray_neg_x  = 1'b0;
  logic                  in_ray_neg_y  = 1'b0;

  logic                  busy;
  logic                  out_valid;
  logic                  out_hit;
  logic                  out_side;
  logic [DIST_OUT_W-1:0] out_distance;
  logic [CELL_W-1:0]     out_cell_x;
  logic [CELL_W-1:0]     out_cell_y;
  logic [PAL_W-1:0]      out_palette;
  logic [SHADE_W-1:0]    out_shade;

  int rays_in_flight;
  int mismatch_count;
  int cycles = 0;
  // When set, transactions go back to back with no idle cycles.
  bit burst  = 1'b0;

  grid_dda_raycaster dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_command   (in_command),
    .in_cell_index(in_cell_index),
    .in_cell_wall (in_cell_wall),
    .in_pos_x     (in_pos_x),
    .in_pos_y     (in_pos_y),
    .in_delta_x   (in_delta_x),
    .in_delta_y   (in_delta_y),
    .in_ray_neg_x (in_ray_neg_x),
    .in_ray_neg_y (in_ray_neg_y),
    .out_valid    (out_valid),
    .out_hit      (out_hit),
    .out_side     (out_side),
    .out_distance (out_distance),
    .out_cell_x   (out_cell_x),
    .out_cell_y   (out_cell_y),
    .out_palette  (out_palette),
    .out_shade    (out_shade)
  );

  // The checker sees the same nets as the block and keeps its own wall map.
  gdr_result_checker result_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_command    (in_command),
    .in_cell_index (in_cell_index),
    .in_cell_wall  (in_cell_wall),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_delta_x    (in_delta_x),
    .in_delta_y    (in_delta_y),
    .in_ray_neg_x  (in_ray_neg_x),
    .in_ray_neg_y  (in_ray_neg_y),
    .out_valid     (out_valid),
    .out_hit       (out_hit),
    .out_side      (out_side),
    .out_distance  (out_distance),
    .out_cell_x    (out_cell_x),
    .out_cell_y    (out_cell_y),
    .out_palette   (out_palette),
    .out_shade     (out_shade),
    .rays_in_flight(rays_in_flight),
    .mismatch_count(mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Drive one transaction after a random idle gap and hold it until the block takes it.
  // A zero gap keeps start high straight into the next transaction.
  task automatic send_command(logic cmd, logic [IDX_W-1:0] idx, logic wall,
                              logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                              logic [DELTA_W-1:0] dx, logic [DELTA_W-1:0] dy,
                              logic nx, logic ny);
    int gap;
    gap = burst ? 0 : int'($urandom_range(0, 10));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_command    <= cmd;
    in_cell_index <= idx;
    in_cell_wall  <= wall;
    in_pos_x      <= px;
    in_pos_y      <= py;
    in_delta_x    <= dx;
    in_delta_y    <= dy;
    in_ray_neg_x  <= nx;
    in_ray_neg_y  <= ny;
    // busy read here is its value before the edge, the one the block acted on.
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Map write; the ray fields carry noise the block must ignore.
  task automatic write_cell(logic [IDX_W-1:0] idx, logic wall);
    send_command(CMD_WRITE, idx, wall, POS_W'($urandom), POS_W'($urandom),
                 DELTA_W'($urandom), DELTA_W'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // Ray cast; the map write fields carry noise.
  task automatic cast_ray(logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                          logic [DELTA_W-1:0] dx, logic [DELTA_W-1:0] dy,
                          logic nx, logic ny);
    send_command(CMD_CAST, IDX_W'($urandom), 1'($urandom), px, py, dx, dy, nx, ny);
  endtask

  // Drop start and hold until every outstanding cast has reported.
  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk);
    while (rays_in_flight != 0) @(posedge clk);
  endtask

  // Small deltas half the time so rays wander over several cells; near-maximum and full-range ones otherwise.
  function automatic logic [DELTA_W-1:0] pick_delta();
    case ($urandom_range(0, 3))
      0:       return DELTA_W'($urandom_range(0, 1023));
      1:       return DELTA_W'($urandom_range(256, 4095));
      2:       return 16'hFFFF - DELTA_W'($urandom_range(0, 255));
      default: return DELTA_W'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    int i;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty map, ray along +X from column 0: the step limit runs out before the edge.
    cast_ray(12'h000, 12'h000, 16'h0001, 16'hFFFF, 1'b0, 1'b0);
    // First step leaves the grid to the left and to the top.
    cast_ray(12'h000, 12'h080, 16'd100, 16'hFFFF, 1'b1, 1'b0);
    cast_ray(12'h5A0, 12'h000, 16'h0000, 16'h0000, 1'b0, 1'b1);
    // Position and delta extremes in both direction senses.
    cast_ray(12'hFFF, 12'hFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
    cast_ray(12'hFFF, 12'hFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);

    // Place walls at both ends of the index range and in the middle.
    write_cell(8'h00, 1'b1);
    write_cell(8'hFF, 1'b1);
    write_cell(8'h88, 1'b1);
    write_cell(8'h87, 1'b1);
    cast_ray(12'h680, 12'h880, 16'h0100, 16'hFFFF, 1'b0, 1'b0);
    // Clear a wall and cast again: the ray must pass through to the next one.
    write_cell(8'h87, 1'b0);
    cast_ray(12'h680, 12'h880, 16'h0100, 16'hFFFF, 1'b0, 1'b0);
    // Y side hit on an odd column.
    write_cell(8'h39, 1'b1);
    cast_ray(12'h980, 12'h580, 16'hFFFF, 16'h0100, 1'b0, 1'b1);
    // Long walk: the distance exceeds seven cells and the shade bottoms out.
    write_cell(8'h05, 1'b1);
    cast_ray(12'h080, 12'h080, 16'h0300, 16'hFFFF, 1'b0, 1'b0);
    // Zero deltas tie every comparison, so the walk runs along Y.
    cast_ray(12'h880, 12'h880, 16'h0000, 16'h0000, 1'b0, 1'b0);
    // Hit the last map cell, and leave through the top with near-zero Y delta.
    cast_ray(12'hEFF, 12'hF00, 16'h0000, 16'hFFFF, 1'b0, 1'b0);
    cast_ray(12'h1FF, 12'h0FF, 16'hFFFF, 16'h0001, 1'b1, 1'b1);
    write_cell(8'h00, 1'b0);

    wait_for_results();

    // Random mix of map writes and casts; gap mode is redrawn every 25 transactions.
    for (i = 0; i < 500; i++) begin
      if (i % 25 == 0) burst = ($urandom_range(0, 3) == 0);
      if (i == 250) wait_for_results();
      if ($urandom_range(0, 9) < 4) write_cell(IDX_W'($urandom), $urandom_range(0, 2) == 0);
      else cast_ray(POS_W'($urandom), POS_W'($urandom), pick_delta(), pick_delta(),
                    1'($urandom), 1'($urandom));
    end

    wait_for_results();
    // Allow for a full cast's latency in case a stray result follows.
    repeat (20) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
